// ===== rtl/core/prq_pkg.sv =====
// prq_pkg: shared types and constants for the priority ready queue
// field widths, op codes, cell commands and parameter defaults
// no dependencies
package prq_pkg;

    // field widths of the channel items
    localparam int OP_W      = 2;
    localparam int TASK_ID_W = 8;
    localparam int TASK_PR_W = 8;

    // parameter defaults
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF       = 8;
    localparam int PRIORITY_BITS_DEF = 8;

    // op codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;

    // command broadcast to every cell of the row
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_cmd_t;

endpackage

// ===== rtl/core/prq_chan_if.sv =====
// prq_chan_if: valid/ready channel interfaces of the priority ready queue
// request channel and result channel; depends on prq_pkg
interface prq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [prq_pkg::OP_W-1:0]              op;
    logic [prq_pkg::TASK_ID_W-1:0]         task_id;
    logic signed [prq_pkg::TASK_PR_W-1:0]  task_priority;

    modport source (output valid, output op, output task_id, output task_priority,
                    input ready);
    modport sink   (input valid, input op, input task_id, input task_priority,
                    output ready);
endinterface

interface prq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [prq_pkg::TASK_ID_W-1:0]  picked_id;
    logic                           picked_valid;
    logic                           queue_nonempty;
    logic                           insert_dropped;

    modport source (output valid, output picked_id, output picked_valid,
                    output queue_nonempty, output insert_dropped, input ready);
    modport sink   (input valid, input picked_id, input picked_valid,
                    input queue_nonempty, input insert_dropped, output ready);
endinterface

// ===== rtl/core/priority_ready_queue.sv =====
// priority_ready_queue: top level of the sorted ready queue
// row of prq_cell slots plus op control and result register
// depends on prq_pkg, prq_chan_if and prq_cell
//
//  channel | dir | payload                                           | taken when
//  req     | in  | op, task_id, task_priority                        | valid && ready
//  rsp     | out | picked_id, picked_valid, queue_nonempty,          | valid && ready
//          |     | insert_dropped                                    |
//
// insert, pick and unused codes finish in a single pass: every cell compares and shifts at once
// a change of a queued id runs a removal pass, then an insert pass from ST_REINSERT
// a change of an absent id ends after the removal pass, which moves no entry
// reset clears the occupancy flags of all cells and the valid flag of the result register
// a result waiting in the output register blocks new items until it is taken
module priority_ready_queue #(
    parameter int QUEUE_DEPTH   = prq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS       = prq_pkg::ID_BITS_DEF,
    parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    prq_req_if.sink    req,
    prq_rsp_if.source  rsp
);

    typedef enum logic [1:0] {
        ST_IDLE     = 2'b01,
        ST_REINSERT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic                            accept;
    prq_pkg::cell_cmd_t              cell_cmd;
    logic [ID_BITS-1:0]              bus_id;
    logic signed [PRIORITY_BITS-1:0] bus_prio;
    logic [ID_BITS-1:0]              in_id;
    logic signed [PRIORITY_BITS-1:0] in_prio;
    logic                            remove_seed;

    logic [ID_BITS-1:0]              pend_id_reg;
    logic [ID_BITS-1:0]              pend_id_next;
    logic signed [PRIORITY_BITS-1:0] pend_prio_reg;
    logic signed [PRIORITY_BITS-1:0] pend_prio_next;

    logic                            cell_valid [QUEUE_DEPTH];
    logic [ID_BITS-1:0]              cell_id    [QUEUE_DEPTH];
    logic signed [PRIORITY_BITS-1:0] cell_prio  [QUEUE_DEPTH];
    logic                            cell_keep  [QUEUE_DEPTH];
    logic                            hit        [QUEUE_DEPTH+1];

    logic                            load_out;
    logic [prq_pkg::TASK_ID_W-1:0]   res_id;
    logic                            res_picked;
    logic                            res_nonempty;
    logic                            res_dropped;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [prq_pkg::TASK_ID_W-1:0]   out_id_reg;
    logic                            out_picked_reg;
    logic                            out_nonempty_reg;
    logic                            out_dropped_reg;

    // item fields at internal widths
    assign in_id   = ID_BITS'(req.task_id);
    assign in_prio = PRIORITY_BITS'(req.task_priority);

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    // op control
    always_comb
    begin
        state_next     = state_reg;
        cell_cmd       = prq_pkg::CELL_HOLD;
        bus_id         = in_id;
        bus_prio       = in_prio;
        remove_seed    = 1'b0;
        pend_id_next   = pend_id_reg;
        pend_prio_next = pend_prio_reg;
        load_out       = 1'b0;
        res_id         = '0;
        res_picked     = 1'b0;
        res_nonempty   = cell_valid[0];
        res_dropped    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        prq_pkg::OP_INSERT:
                        begin
                            load_out     = 1'b1;
                            res_nonempty = 1'b1;
                            if (cell_valid[QUEUE_DEPTH-1])
                            begin
                                res_dropped = 1'b1;
                            end
                            else
                            begin
                                cell_cmd = prq_pkg::CELL_INSERT;
                            end
                        end
                        prq_pkg::OP_PICK:
                        begin
                            cell_cmd     = prq_pkg::CELL_REMOVE;
                            remove_seed  = 1'b1;
                            load_out     = 1'b1;
                            res_picked   = cell_valid[0];
                            res_id       = cell_valid[0] ?
                                           prq_pkg::TASK_ID_W'(cell_id[0]) : '0;
                            res_nonempty = (QUEUE_DEPTH > 1) ? cell_valid[1] : 1'b0;
                        end
                        prq_pkg::OP_CHANGE:
                        begin
                            cell_cmd = prq_pkg::CELL_REMOVE;
                            if (hit[QUEUE_DEPTH])
                            begin
                                pend_id_next   = in_id;
                                pend_prio_next = in_prio;
                                state_next     = ST_REINSERT;
                            end
                            else
                            begin
                                load_out = 1'b1;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_REINSERT:
            begin
                cell_cmd     = prq_pkg::CELL_INSERT;
                bus_id       = pend_id_reg;
                bus_prio     = pend_prio_reg;
                load_out     = 1'b1;
                res_nonempty = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // row of cells, head at index zero
    assign hit[0] = remove_seed;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                            l_valid;
        logic [ID_BITS-1:0]              l_id;
        logic signed [PRIORITY_BITS-1:0] l_prio;
        logic                            l_keep;
        logic                            r_valid;
        logic [ID_BITS-1:0]              r_id;
        logic signed [PRIORITY_BITS-1:0] r_prio;

        if (i == 0)
        begin : g_head
            assign l_valid = 1'b0;
            assign l_id    = '0;
            assign l_prio  = '0;
            assign l_keep  = 1'b1;
        end
        else
        begin : g_mid
            assign l_valid = cell_valid[i-1];
            assign l_id    = cell_id[i-1];
            assign l_prio  = cell_prio[i-1];
            assign l_keep  = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_id    = '0;
            assign r_prio  = '0;
        end
        else
        begin : g_body
            assign r_valid = cell_valid[i+1];
            assign r_id    = cell_id[i+1];
            assign r_prio  = cell_prio[i+1];
        end

        prq_cell #(
            .ID_BITS       (ID_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cell_cmd),
            .new_id      (bus_id),
            .new_prio    (bus_prio),
            .left_valid  (l_valid),
            .left_id     (l_id),
            .left_prio   (l_prio),
            .left_keep   (l_keep),
            .hit_in      (hit[i]),
            .right_valid (r_valid),
            .right_id    (r_id),
            .right_prio  (r_prio),
            .valid       (cell_valid[i]),
            .id          (cell_id[i]),
            .prio        (cell_prio[i]),
            .keep        (cell_keep[i]),
            .hit_out     (hit[i+1])
        );
    end

    // result register handshake
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg   <= pend_id_next;
        pend_prio_reg <= pend_prio_next;
        if (load_out)
        begin
            out_id_reg       <= res_id;
            out_picked_reg   <= res_picked;
            out_nonempty_reg <= res_nonempty;
            out_dropped_reg  <= res_dropped;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.picked_id      = out_id_reg;
    assign rsp.picked_valid   = out_picked_reg;
    assign rsp.queue_nonempty = out_nonempty_reg;
    assign rsp.insert_dropped = out_dropped_reg;

endmodule

// ===== rtl/core/prq_cell.sv =====
// prq_cell: one slot of the sorted queue row
// holds one entry and trades it with its neighbors; depends on prq_pkg
module prq_cell #(
    parameter int ID_BITS       = prq_pkg::ID_BITS_DEF,
    parameter int PRIORITY_BITS = prq_pkg::PRIORITY_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  prq_pkg::cell_cmd_t              cmd,
    input  logic [ID_BITS-1:0]              new_id,
    input  logic signed [PRIORITY_BITS-1:0] new_prio,
    // neighbor toward the head
    input  logic                            left_valid,
    input  logic [ID_BITS-1:0]              left_id,
    input  logic signed [PRIORITY_BITS-1:0] left_prio,
    input  logic                            left_keep,
    input  logic                            hit_in,
    // neighbor toward the tail
    input  logic                            right_valid,
    input  logic [ID_BITS-1:0]              right_id,
    input  logic signed [PRIORITY_BITS-1:0] right_prio,
    // own entry and chain outputs
    output logic                            valid,
    output logic [ID_BITS-1:0]              id,
    output logic signed [PRIORITY_BITS-1:0] prio,
    output logic                            keep,
    output logic                            hit_out
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [ID_BITS-1:0]              id_reg;
    logic [ID_BITS-1:0]              id_next;
    logic signed [PRIORITY_BITS-1:0] prio_reg;
    logic signed [PRIORITY_BITS-1:0] prio_next;

    // entry stays ahead of a new one of the same or lower priority
    assign keep    = valid_reg && (prio_reg >= new_prio);
    // removal point is at or before this cell
    assign hit_out = hit_in || (valid_reg && (id_reg == new_id));

    // next entry of the cell
    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        case (cmd)
            prq_pkg::CELL_INSERT:
            begin
                if (!keep)
                begin
                    if (left_keep)
                    begin
                        valid_next = 1'b1;
                        id_next    = new_id;
                        prio_next  = new_prio;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        id_next    = left_id;
                        prio_next  = left_prio;
                    end
                end
            end
            prq_pkg::CELL_REMOVE:
            begin
                if (hit_out)
                begin
                    valid_next = right_valid;
                    id_next    = right_id;
                    prio_next  = right_prio;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign prio  = prio_reg;

endmodule
